// ===== rtl/range_scan_reprojection_merge_assert.svh =====
// ----------------------------------------------------------------------------
// Range scan reprojection merge: assertion macros
// Concurrent checks on i_clk, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RANGE_SCAN_REPROJECTION_MERGE_ASSERT_SVH
`define RANGE_SCAN_REPROJECTION_MERGE_ASSERT_SVH

`ifndef SYNTHESIS
// check with reset masking
`define RSRM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("rsrm assertion failed");
// check that also runs during reset
`define RSRM_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("rsrm reset assertion failed");
`else
`define RSRM_ASSERT(lbl, prop)
`define RSRM_ASSERT_RST(lbl, prop)
`endif

`endif

// ===== rtl/rsrm_pkg.sv =====
// ----------------------------------------------------------------------------
// Range scan reprojection merge package
// Item types, fixed-point constants and the arctangent table.
// ----------------------------------------------------------------------------
package rsrm_pkg;

    localparam int BIN_COUNT = 360;
    localparam int BIN_AW    = $clog2(BIN_COUNT);

    // datapath widths
    localparam int X_W   = 40;   // Q16 millimetre vectors
    localparam int Z_W   = 22;   // Q16 radian angles
    localparam int NUM_W = 22;   // bin divider numerator
    localparam int DEN_W = 20;   // bin divider denominator

    localparam int CORDIC_STEPS = 17;

    localparam logic signed [Z_W-1:0] ANG_PI      = 22'sd205887;
    localparam logic signed [Z_W-1:0] ANG_TWO_PI  = 22'sd411775;
    localparam logic signed [Z_W-1:0] ANG_HALF_PI = 22'sd102944;
    localparam logic [15:0]           INV_GAIN    = 16'd39797;

    // operation codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_BEAM  = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_OFFSET_X   = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y   = 3'd1;
    localparam logic [2:0] REG_SENSOR_YAW = 3'd2;
    localparam logic [2:0] REG_BEAM_START = 3'd3;
    localparam logic [2:0] REG_BEAM_STEP  = 3'd4;
    localparam logic [2:0] REG_RNG_FLOOR  = 3'd5;
    localparam logic [2:0] REG_RNG_CEIL   = 3'd6;
    localparam logic [2:0] REG_BIN_WIDTH  = 3'd7;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] range_mm;
        logic        range_finite;
        logic [8:0]  bin_index;
    } t_in_item;

    typedef struct packed {
        logic [15:0] bin_range;
        logic        bin_filled;
    } t_out_item;

    typedef struct packed {
        logic                  start;
        logic                  vectoring;
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
        logic signed [Z_W-1:0] z;
    } t_cordic_cmd;

    typedef struct packed {
        logic                  done;
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
        logic signed [Z_W-1:0] z;
    } t_cordic_res;

    // arctangent of 2^-i in Q16 radians
    function automatic logic [Z_W-1:0] atan_q16(input logic [4:0] i);
        logic [Z_W-1:0] a;
        case (i)
            5'd0:    a = 22'd51472;
            5'd1:    a = 22'd30386;
            5'd2:    a = 22'd16055;
            5'd3:    a = 22'd8150;
            5'd4:    a = 22'd4091;
            5'd5:    a = 22'd2047;
            5'd6:    a = 22'd1024;
            5'd7:    a = 22'd512;
            5'd8:    a = 22'd256;
            5'd9:    a = 22'd128;
            5'd10:   a = 22'd64;
            5'd11:   a = 22'd32;
            5'd12:   a = 22'd16;
            5'd13:   a = 22'd8;
            5'd14:   a = 22'd4;
            5'd15:   a = 22'd2;
            5'd16:   a = 22'd1;
            default: a = 22'd0;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/rsrm_cordic.sv =====
// ----------------------------------------------------------------------------
// Range scan reprojection merge: shared CORDIC unit
// One micro-rotation per cycle, rotation or vectoring mode, 17 steps.
// ----------------------------------------------------------------------------
module rsrm_cordic (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rsrm_pkg::t_cordic_cmd i_cmd,
    output rsrm_pkg::t_cordic_res o_res
);

    logic signed [rsrm_pkg::X_W-1:0] r_x, n_x, r_y, n_y, dx, dy;
    logic signed [rsrm_pkg::Z_W-1:0] r_z, n_z, ang;
    logic [4:0] r_cnt, n_cnt;
    logic       r_busy, n_busy, r_done, n_done, r_vec, n_vec, sub;

    assign dx  = r_y >>> r_cnt;
    assign dy  = r_x >>> r_cnt;
    assign ang = signed'(rsrm_pkg::atan_q16(r_cnt));
    assign sub = r_vec ? r_y[rsrm_pkg::X_W-1] : !r_z[rsrm_pkg::Z_W-1];

    always_comb begin
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_vec  = r_vec;
        n_done = 1'b0;
        if (i_cmd.start) begin
            // load, with a quarter-turn pre-rotation where the operand needs one
            n_busy = 1'b1;
            n_cnt  = 5'd0;
            n_vec  = i_cmd.vectoring;
            n_x    = i_cmd.x;
            n_y    = i_cmd.y;
            n_z    = i_cmd.z;
            if (i_cmd.vectoring) begin
                n_z = '0;
                if (i_cmd.x < 0) begin
                    if (i_cmd.y >= 0) begin
                        n_x = i_cmd.y;
                        n_y = -i_cmd.x;
                        n_z = rsrm_pkg::ANG_HALF_PI;
                    end else begin
                        n_x = -i_cmd.y;
                        n_y = i_cmd.x;
                        n_z = -rsrm_pkg::ANG_HALF_PI;
                    end
                end
            end else if (i_cmd.z > rsrm_pkg::ANG_HALF_PI) begin
                n_x = '0;
                n_y = i_cmd.x;
                n_z = i_cmd.z - rsrm_pkg::ANG_HALF_PI;
            end else if (i_cmd.z < -rsrm_pkg::ANG_HALF_PI) begin
                n_x = '0;
                n_y = -i_cmd.x;
                n_z = i_cmd.z + rsrm_pkg::ANG_HALF_PI;
            end
        end else if (r_busy) begin
            // micro-rotation step
            if (sub) begin
                n_x = r_x - dx;
                n_y = r_y + dy;
                n_z = r_z - ang;
            end else begin
                n_x = r_x + dx;
                n_y = r_y - dy;
                n_z = r_z + ang;
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'(rsrm_pkg::CORDIC_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_vec  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_vec  <= n_vec;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_res.done = r_done;
    assign o_res.x    = r_x;
    assign o_res.y    = r_y;
    assign o_res.z    = r_z;

endmodule

// ===== rtl/rsrm_div.sv =====
// ----------------------------------------------------------------------------
// Range scan reprojection merge: bin index divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsrm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rsrm_pkg::NUM_W-1:0]  i_num,
    input  logic [rsrm_pkg::DEN_W-1:0]  i_den,
    output logic                        o_done,
    output logic [rsrm_pkg::NUM_W-1:0]  o_quot
);

    logic [rsrm_pkg::NUM_W-1:0] r_quot, n_quot;
    logic [rsrm_pkg::DEN_W-1:0] r_rem, n_rem, r_den;
    logic [rsrm_pkg::DEN_W:0]   rem_sh;
    logic [4:0] r_cnt, n_cnt;
    logic       r_busy, n_busy, r_done, n_done;

    assign rem_sh = {r_rem, r_quot[rsrm_pkg::NUM_W-1]};

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_quot = i_num;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // shift in one numerator bit, subtract if it fits
            if (rem_sh >= {1'b0, r_den}) begin
                n_rem  = rsrm_pkg::DEN_W'(rem_sh - {1'b0, r_den});
                n_quot = {r_quot[rsrm_pkg::NUM_W-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh[rsrm_pkg::DEN_W-1:0];
                n_quot = {r_quot[rsrm_pkg::NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'(rsrm_pkg::NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== rtl/range_scan_reprojection_merge.sv =====
// ----------------------------------------------------------------------------
// Range scan reprojection merge: top level
// Merges range beams into a polar grid of nearest distances.
// ----------------------------------------------------------------------------
// Accepted beam sample: next input transfer after the heading fold, two CORDIC
// passes, the 22-step bin divider and the bin update (bin in range only).
// Rejected sample and start source: no busy state. Read bin: memory read, then
// S_OUT until the output register is free. Clear bins: sweep of all 360 bin
// memory entries, one entry a cycle. Reset is synchronous; the same sweep runs
// after reset, no input transfer is taken meanwhile (configuration writes are).
`include "range_scan_reprojection_merge_assert.svh"

module range_scan_reprojection_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rsrm_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rsrm_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [19:0]         i_cfg_data
);

    localparam int AW = rsrm_pkg::BIN_AW;
    localparam int XW = rsrm_pkg::X_W;
    localparam int ZW = rsrm_pkg::Z_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SWEEP = 4'd1;
    localparam logic [3:0] S_WRAP  = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_ROT   = 4'd4;
    localparam logic [3:0] S_VEC   = 4'd5;
    localparam logic [3:0] S_DIST  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_WR    = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    // configuration registers
    logic signed [15:0] r_off_x, r_off_y;
    logic signed [19:0] r_yaw, r_beam_start, r_beam_step, r_beam;
    logic [15:0]        r_floor, r_ceil;
    logic [18:0]        r_bin_w;

    logic [3:0]             r_state, n_state;
    logic [AW-1:0]          r_sweep, n_sweep;
    logic signed [ZW-1:0]   r_z, n_z;
    logic [15:0]            r_rng;
    logic [31:0]            r_prod;
    logic [XW-2:0]          r_xd;
    logic [54:0]            r_dprod;
    logic                   r_neg, r_rd_ok, n_rd_ok;
    logic                   r_out_valid;
    rsrm_pkg::t_out_item    r_out_data;
    logic [AW-1:0]          r_wa;

    // bin memory: {filled, nearest distance}
    logic [16:0] mem [rsrm_pkg::BIN_COUNT];
    logic [16:0] r_mem_q, mem_wd;
    logic [AW-1:0] mem_wa, mem_ra;
    logic          mem_we, mem_re;

    rsrm_pkg::t_cordic_cmd cord_cmd;
    rsrm_pkg::t_cordic_res cord_res;
    logic                          div_start, div_done;
    logic [rsrm_pkg::NUM_W-1:0]    div_num, div_quot;
    logic [rsrm_pkg::DEN_W-1:0]    div_den;

    logic        in_xfer, out_free, smp_ok, bin_ok;
    logic [18:0] w_eff;
    logic signed [ZW-1:0] diff;
    logic [ZW-1:0]        mag;
    logic [54:0]          dsum;
    logic [22:0]          dq;
    logic [15:0]          near_dist;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign smp_ok      = i_in_data.range_finite && (i_in_data.range_mm >= r_floor)
                         && (i_in_data.range_mm <= r_ceil);

    // bin arithmetic: rounded index and saturated distance
    assign w_eff = (r_bin_w == '0) ? 19'd1 : r_bin_w;
    assign diff  = cord_res.z - (-rsrm_pkg::ANG_PI);
    assign mag   = diff[ZW-1] ? ZW'(-diff) : ZW'(diff);
    assign dsum  = r_dprod + 55'(64'd2147483648);
    assign dq    = dsum[54:32];
    assign near_dist = (dq > 23'd65535) ? 16'hFFFF : dq[15:0];
    assign bin_ok = (!r_neg || div_quot == '0)
                    && (32'(div_quot) < rsrm_pkg::BIN_COUNT);

    rsrm_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cord_cmd),
        .o_res   (cord_res)
    );

    rsrm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_sweep   = r_sweep;
        n_z       = r_z;
        n_rd_ok   = r_rd_ok;
        cord_cmd  = '0;
        div_start = 1'b0;
        div_num   = rsrm_pkg::NUM_W'({mag, 1'b0} + (ZW+1)'(w_eff));
        div_den   = {w_eff, 1'b0};
        mem_we    = 1'b0;
        mem_wa    = r_sweep;
        mem_wd    = '0;
        mem_re    = 1'b0;
        mem_ra    = i_in_data.bin_index[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    unique case (i_in_data.op)
                        rsrm_pkg::OP_CLEAR: begin
                            n_sweep = '0;
                            n_state = S_SWEEP;
                        end
                        rsrm_pkg::OP_START: begin
                            n_state = S_IDLE;
                        end
                        rsrm_pkg::OP_BEAM: begin
                            n_z = ZW'(r_beam) + ZW'(r_yaw);
                            if (smp_ok) begin
                                n_state = S_WRAP;
                            end
                        end
                        default: begin
                            n_rd_ok = (32'(i_in_data.bin_index) < rsrm_pkg::BIN_COUNT);
                            mem_re  = n_rd_ok;
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                mem_we  = 1'b1;
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == AW'(rsrm_pkg::BIN_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_WRAP: begin
                // fold heading into [-pi, pi]
                if (r_z > rsrm_pkg::ANG_PI) begin
                    n_z = r_z - rsrm_pkg::ANG_TWO_PI;
                end else if (r_z < -rsrm_pkg::ANG_PI) begin
                    n_z = r_z + rsrm_pkg::ANG_TWO_PI;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                cord_cmd.start = 1'b1;
                cord_cmd.x     = XW'(signed'({1'b0, r_prod}));
                cord_cmd.z     = r_z;
                n_state        = S_ROT;
            end
            S_ROT: begin
                if (cord_res.done) begin
                    // shift by mounting offset, then back to polar
                    cord_cmd.start     = 1'b1;
                    cord_cmd.vectoring = 1'b1;
                    cord_cmd.x = cord_res.x + XW'(signed'({r_off_x, 16'h0000}));
                    cord_cmd.y = cord_res.y + XW'(signed'({r_off_y, 16'h0000}));
                    n_state    = S_VEC;
                end
            end
            S_VEC: begin
                if (cord_res.done) begin
                    div_start = 1'b1;
                    n_state   = S_DIST;
                end
            end
            S_DIST: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    mem_ra = div_quot[AW-1:0];
                    mem_re = bin_ok;
                    n_state = bin_ok ? S_WR : S_IDLE;
                end
            end
            S_WR: begin
                // keep the nearest distance
                mem_wa = r_wa;
                mem_wd = {1'b1, near_dist};
                mem_we = !r_mem_q[16] || (near_dist < r_mem_q[15:0]);
                n_state = S_IDLE;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_sweep      <= '0;
            r_rd_ok      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_beam       <= '0;
            r_off_x      <= '0;
            r_off_y      <= '0;
            r_yaw        <= '0;
            r_beam_start <= -20'sd205887;
            r_beam_step  <= 20'sd1144;
            r_floor      <= 16'd300;
            r_ceil       <= 16'd12000;
            r_bin_w      <= 19'd1144;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_rd_ok <= n_rd_ok;
            // beam angle bookkeeping
            if (in_xfer && i_in_data.op == rsrm_pkg::OP_START) begin
                r_beam <= r_beam_start;
            end else if (in_xfer && i_in_data.op == rsrm_pkg::OP_BEAM) begin
                r_beam <= r_beam + r_beam_step;
            end
            // output register
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // configuration writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    rsrm_pkg::REG_OFFSET_X:   r_off_x      <= i_cfg_data[15:0];
                    rsrm_pkg::REG_OFFSET_Y:   r_off_y      <= i_cfg_data[15:0];
                    rsrm_pkg::REG_SENSOR_YAW: r_yaw        <= i_cfg_data;
                    rsrm_pkg::REG_BEAM_START: r_beam_start <= i_cfg_data;
                    rsrm_pkg::REG_BEAM_STEP:  r_beam_step  <= i_cfg_data;
                    rsrm_pkg::REG_RNG_FLOOR:  r_floor      <= i_cfg_data[15:0];
                    rsrm_pkg::REG_RNG_CEIL:   r_ceil       <= i_cfg_data[15:0];
                    default:                  r_bin_w      <= i_cfg_data[18:0];
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_z    <= n_z;
        r_prod <= r_rng * rsrm_pkg::INV_GAIN;
        if (in_xfer) begin
            r_rng <= i_in_data.range_mm;
        end
        if (r_state == S_VEC && cord_res.done) begin
            r_xd  <= cord_res.x[XW-1] ? '0 : cord_res.x[XW-2:0];
            r_neg <= diff[ZW-1];
        end
        if (r_state == S_DIST) begin
            r_dprod <= 55'(r_xd) * 55'(rsrm_pkg::INV_GAIN);
        end
        if (r_state == S_DIV && div_done) begin
            r_wa <= div_quot[AW-1:0];
        end
        if (r_state == S_OUT && out_free) begin
            r_out_data.bin_filled <= r_rd_ok && r_mem_q[16];
            r_out_data.bin_range  <= (r_rd_ok && r_mem_q[16]) ? r_mem_q[15:0] : 16'h0;
        end
    end

    // bin memory ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q <= mem[mem_ra];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `RSRM_ASSERT_RST(a_reset_sweeps, (!i_rst_n) |=> (r_state == S_SWEEP && r_sweep == '0))
    `RSRM_ASSERT(a_cordic_done_busy, cord_res.done |-> (r_state == S_ROT || r_state == S_VEC))
    `RSRM_ASSERT(a_div_done_state, div_done |-> (r_state == S_DIV))
    `RSRM_ASSERT(a_write_in_grid, mem_we |-> (32'(mem_wa) < rsrm_pkg::BIN_COUNT))

endmodule
